// File: design/lobm_pkg.sv
package lobm_pkg;

    localparam int NSLOT = 32;
    localparam int SLOT_W = 5;
    localparam int NSEEN = 1024;
    localparam int SEEN_W = 10;
    localparam int QCNT_W = 2;

    localparam logic [19:0] QTY_MAX = 20'd1000000;
    localparam logic [29:0] PRICE_MAX = 30'd1000000000;
    localparam logic [6:0] DEPTH_CAP = 7'd100;

    localparam logic [1:0] REQ_ADD = 2'd0;
    localparam logic [1:0] REQ_CANCEL = 2'd1;
    localparam logic [1:0] REQ_DEPTH = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [2:0] RK_TRADE = 3'd0;
    localparam logic [2:0] RK_ADD = 3'd1;
    localparam logic [2:0] RK_REJECT = 3'd2;
    localparam logic [2:0] RK_CANCEL = 3'd3;
    localparam logic [2:0] RK_BID = 3'd4;
    localparam logic [2:0] RK_ASK = 3'd5;
    localparam logic [2:0] RK_END = 3'd6;

    localparam logic [3:0] ST_OK = 4'd0;
    localparam logic [3:0] ST_BAD_ID = 4'd1;
    localparam logic [3:0] ST_BAD_SIDE = 4'd2;
    localparam logic [3:0] ST_BAD_QTY = 4'd3;
    localparam logic [3:0] ST_BAD_PRICE = 4'd4;
    localparam logic [3:0] ST_DUP = 4'd5;
    localparam logic [3:0] ST_CAPACITY = 4'd6;
    localparam logic [3:0] ST_EXPIRED = 4'd7;
    localparam logic [3:0] ST_UNKNOWN = 4'd8;
    localparam logic [3:0] ST_CANCELLED = 4'd9;
    localparam logic [3:0] ST_BOOK = 4'd10;

    localparam logic CFG_ACTIVE_LIMIT = 1'b0;
    localparam logic CFG_SEEN_LIMIT = 1'b1;

    typedef struct packed {
        logic [1:0] req_type;
        logic [31:0] order_id;
        logic [1:0] side;
        logic is_market;
        logic [29:0] price;
        logic [19:0] quantity;
        logic [7:0] depth_levels;
    } req_t;

    typedef struct packed {
        logic [2:0] result_kind;
        logic [3:0] status;
        logic [31:0] taker_id;
        logic [31:0] maker_id;
        logic [29:0] level_price;
        logic [24:0] amount;
        logic [5:0] order_count;
        logic last;
    } res_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [31:0] id;
        logic side;
        logic market;
        logic [29:0] price;
        logic [19:0] qty;
        logic [6:0] want;
        logic [3:0] code;
    } cmd_t;

endpackage

// File: design/lobm_ram.sv
module lobm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/lobm_front.sv
module lobm_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  lobm_pkg::req_t   req,
    output logic             q_valid,
    input  logic             q_pop,
    output lobm_pkg::cmd_t   q_cmd
);

    lobm_pkg::cmd_t cls;
    lobm_pkg::cmd_t q_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic wr;

    always_comb
    begin
        cls.kind = req.req_type;
        cls.id = req.order_id;
        cls.side = req.side[0];
        cls.market = req.is_market;
        cls.price = req.price;
        cls.qty = req.quantity;
        cls.want = (req.depth_levels > {1'b0, lobm_pkg::DEPTH_CAP}) ?
                   lobm_pkg::DEPTH_CAP : req.depth_levels[6:0];
        if (req.order_id == 32'd0)
            cls.code = lobm_pkg::ST_BAD_ID;
        else if (req.side[1])
            cls.code = lobm_pkg::ST_BAD_SIDE;
        else if (req.quantity == 20'd0 || req.quantity > lobm_pkg::QTY_MAX)
            cls.code = lobm_pkg::ST_BAD_QTY;
        else if (!req.is_market &&
                 (req.price == 30'd0 || req.price > lobm_pkg::PRICE_MAX))
            cls.code = lobm_pkg::ST_BAD_PRICE;
        else
            cls.code = lobm_pkg::ST_OK;
    end

    assign full = (cnt_reg == 2'd2);
    assign wr = push && !full && (req.req_type != lobm_pkg::REQ_UNUSED);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            q_reg[wp_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
                wp_reg <= !wp_reg;
            if (q_pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, q_pop};
        end
    end

endmodule

// File: design/lobm_engine.sv
module lobm_engine (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_pop,
    input  lobm_pkg::cmd_t  q_cmd,
    input  logic            oq_full,
    output logic            o_push,
    output lobm_pkg::res_t  o_item,
    input  logic [5:0]      act_lim,
    input  logic [10:0]     seen_lim
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_DUPRD = 12'b000000000010,
        S_DUPCM = 12'b000000000100,
        S_CAP   = 12'b000000001000,
        S_MSCAN = 12'b000000010000,
        S_MDEC  = 12'b000000100000,
        S_END   = 12'b000001000000,
        S_CSCAN = 12'b000010000000,
        S_DNEXT = 12'b000100000000,
        S_DLVL  = 12'b001000000000,
        S_DSUM  = 12'b010000000000,
        S_DEMIT = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    lobm_pkg::cmd_t cmd_reg, cmd_next;
    logic [3:0] code_reg, code_next;
    logic [lobm_pkg::SLOT_W-1:0] i_reg, i_next, best_reg, best_next;
    logic [lobm_pkg::SEEN_W-1:0] si_reg, si_next, arr_reg, arr_next;
    logic [10:0] seen_cnt_reg, seen_cnt_next;
    logic [5:0] act_reg, act_next;
    logic found_reg, found_next;
    logic [29:0] bp_reg, bp_next;
    logic [10:0] barr_reg, barr_next;
    logic [19:0] bq_reg, bq_next, left_reg, left_next;
    logic [31:0] bid_reg, bid_next;
    logic ds_reg, ds_next, bnd_reg, bnd_next;
    logic [29:0] bound_reg, bound_next;
    logic [6:0] k_reg, k_next;
    logic [24:0] tot_reg, tot_next;
    logic [5:0] cnt_reg, cnt_next;

    logic sv_reg [lobm_pkg::NSLOT];
    logic [31:0] sid_reg [lobm_pkg::NSLOT];
    logic sside_reg [lobm_pkg::NSLOT];
    logic [29:0] sprice_reg [lobm_pkg::NSLOT];
    logic [19:0] sqty_reg [lobm_pkg::NSLOT];
    logic [10:0] sarr_reg [lobm_pkg::NSLOT];

    logic ram_we;
    logic [31:0] ram_rdata;
    logic cur_v, cur_side;
    logic [31:0] cur_id;
    logic [29:0] cur_p;
    logic [19:0] cur_q;
    logic [10:0] cur_a;
    logic last_i;
    logic [5:0] al;
    logic [10:0] sl;
    logic [lobm_pkg::SLOT_W-1:0] free_idx;
    logic [19:0] ex;
    logic hit, better, crossed;
    logic w_new, w_trade, w_clr;

    lobm_ram #(.WIDTH(32), .DEPTH(lobm_pkg::NSEEN)) u_seen (
        .clk(clk),
        .we(ram_we),
        .waddr(seen_cnt_reg[lobm_pkg::SEEN_W-1:0]),
        .wdata(cmd_reg.id),
        .raddr(si_reg),
        .rdata(ram_rdata)
    );

    assign cur_v = sv_reg[i_reg];
    assign cur_side = sside_reg[i_reg];
    assign cur_id = sid_reg[i_reg];
    assign cur_p = sprice_reg[i_reg];
    assign cur_q = sqty_reg[i_reg];
    assign cur_a = sarr_reg[i_reg];
    assign last_i = (i_reg == lobm_pkg::SLOT_W'(lobm_pkg::NSLOT - 1));
    assign al = (act_lim > 6'(lobm_pkg::NSLOT)) ? 6'(lobm_pkg::NSLOT) : act_lim;
    assign sl = (seen_lim > 11'(lobm_pkg::NSEEN)) ? 11'(lobm_pkg::NSEEN) : seen_lim;
    assign ex = (left_reg < bq_reg) ? left_reg : bq_reg;

    always_comb
    begin
        free_idx = '0;
        for (int n = lobm_pkg::NSLOT - 1; n >= 0; n--)
        begin
            if (!sv_reg[n])
                free_idx = lobm_pkg::SLOT_W'(n);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        code_next = code_reg;
        i_next = i_reg;
        best_next = best_reg;
        si_next = si_reg;
        arr_next = arr_reg;
        seen_cnt_next = seen_cnt_reg;
        act_next = act_reg;
        found_next = found_reg;
        bp_next = bp_reg;
        barr_next = barr_reg;
        bq_next = bq_reg;
        bid_next = bid_reg;
        left_next = left_reg;
        ds_next = ds_reg;
        bnd_next = bnd_reg;
        bound_next = bound_reg;
        k_next = k_reg;
        tot_next = tot_reg;
        cnt_next = cnt_reg;
        q_pop = 1'b0;
        o_push = 1'b0;
        o_item = '0;
        ram_we = 1'b0;
        w_new = 1'b0;
        w_trade = 1'b0;
        w_clr = 1'b0;
        hit = 1'b0;
        better = 1'b0;
        crossed = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    cmd_next = q_cmd;
                    code_next = q_cmd.code;
                    i_next = '0;
                    si_next = '0;
                    ds_next = 1'b0;
                    k_next = '0;
                    bnd_next = 1'b0;
                    case (q_cmd.kind)
                        lobm_pkg::REQ_ADD:
                            state_next = (q_cmd.code != lobm_pkg::ST_OK ||
                                          seen_cnt_reg == 11'd0) ? S_CAP : S_DUPRD;
                        lobm_pkg::REQ_CANCEL:
                            state_next = S_CSCAN;
                        default:
                            state_next = S_DNEXT;
                    endcase
                end
            end
            S_DUPRD:
            begin
                state_next = S_DUPCM;
            end
            S_DUPCM:
            begin
                if (ram_rdata == cmd_reg.id)
                begin
                    code_next = lobm_pkg::ST_DUP;
                    state_next = S_CAP;
                end
                else if ({1'b0, si_reg} + 11'd1 >= seen_cnt_reg)
                    state_next = S_CAP;
                else
                begin
                    si_next = si_reg + 1'b1;
                    state_next = S_DUPRD;
                end
            end
            S_CAP:
            begin
                if (code_reg == lobm_pkg::ST_OK && seen_cnt_reg < sl && act_reg < al)
                begin
                    ram_we = 1'b1;
                    arr_next = seen_cnt_reg[lobm_pkg::SEEN_W-1:0];
                    seen_cnt_next = seen_cnt_reg + 11'd1;
                    left_next = cmd_reg.qty;
                    i_next = '0;
                    found_next = 1'b0;
                    state_next = S_MSCAN;
                end
                else if (!oq_full)
                begin
                    o_push = 1'b1;
                    o_item.result_kind = lobm_pkg::RK_REJECT;
                    o_item.status = (code_reg == lobm_pkg::ST_OK) ?
                                    lobm_pkg::ST_CAPACITY : code_reg;
                    o_item.taker_id = cmd_reg.id;
                    o_item.last = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_MSCAN:
            begin
                if (cur_v && cur_side != cmd_reg.side)
                begin
                    better = cur_side ? (cur_p < bp_reg) : (cur_p > bp_reg);
                    if (!found_reg || better || (cur_p == bp_reg && cur_a < barr_reg))
                    begin
                        found_next = 1'b1;
                        best_next = i_reg;
                        bp_next = cur_p;
                        barr_next = cur_a;
                        bq_next = cur_q;
                        bid_next = cur_id;
                    end
                end
                i_next = i_reg + 1'b1;
                if (last_i)
                    state_next = S_MDEC;
            end
            S_MDEC:
            begin
                crossed = found_reg && (cmd_reg.market ||
                          (cmd_reg.side ? (bp_reg >= cmd_reg.price)
                                        : (bp_reg <= cmd_reg.price)));
                if (!crossed)
                    state_next = S_END;
                else if (!oq_full)
                begin
                    o_push = 1'b1;
                    o_item.result_kind = lobm_pkg::RK_TRADE;
                    o_item.status = lobm_pkg::ST_OK;
                    o_item.taker_id = cmd_reg.id;
                    o_item.maker_id = bid_reg;
                    o_item.level_price = bp_reg;
                    o_item.amount = 25'(ex);
                    w_trade = 1'b1;
                    if (ex == bq_reg)
                        act_next = act_reg - 6'd1;
                    left_next = left_reg - ex;
                    i_next = '0;
                    found_next = 1'b0;
                    state_next = (left_reg == ex) ? S_END : S_MSCAN;
                end
            end
            S_END:
            begin
                if (!oq_full)
                begin
                    o_push = 1'b1;
                    o_item.result_kind = lobm_pkg::RK_ADD;
                    o_item.status = (cmd_reg.market && left_reg != 20'd0) ?
                                    lobm_pkg::ST_EXPIRED : lobm_pkg::ST_OK;
                    o_item.taker_id = cmd_reg.id;
                    o_item.amount = 25'(left_reg);
                    o_item.last = 1'b1;
                    if (left_reg != 20'd0 && !cmd_reg.market)
                    begin
                        w_new = 1'b1;
                        act_next = act_reg + 6'd1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_CSCAN:
            begin
                hit = cur_v && cur_id == cmd_reg.id && cmd_reg.id != 32'd0;
                if (hit || last_i)
                begin
                    if (!oq_full)
                    begin
                        o_push = 1'b1;
                        o_item.taker_id = cmd_reg.id;
                        o_item.last = 1'b1;
                        if (hit)
                        begin
                            o_item.result_kind = lobm_pkg::RK_CANCEL;
                            o_item.status = lobm_pkg::ST_CANCELLED;
                            o_item.amount = 25'(cur_q);
                            w_clr = 1'b1;
                            act_next = act_reg - 6'd1;
                        end
                        else
                        begin
                            o_item.result_kind = lobm_pkg::RK_REJECT;
                            o_item.status = lobm_pkg::ST_UNKNOWN;
                        end
                        state_next = S_IDLE;
                    end
                end
                else
                    i_next = i_reg + 1'b1;
            end
            S_DNEXT:
            begin
                if (k_reg < cmd_reg.want)
                begin
                    i_next = '0;
                    found_next = 1'b0;
                    state_next = S_DLVL;
                end
                else if (!ds_reg)
                begin
                    ds_next = 1'b1;
                    k_next = '0;
                    bnd_next = 1'b0;
                end
                else if (!oq_full)
                begin
                    o_push = 1'b1;
                    o_item.result_kind = lobm_pkg::RK_END;
                    o_item.status = lobm_pkg::ST_BOOK;
                    o_item.last = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DLVL:
            begin
                hit = cur_v && cur_side == ds_reg &&
                      (!bnd_reg || (ds_reg ? (cur_p > bound_reg) : (cur_p < bound_reg))) &&
                      (!found_reg || (ds_reg ? (cur_p < bp_reg) : (cur_p > bp_reg)));
                if (hit)
                begin
                    bp_next = cur_p;
                    found_next = 1'b1;
                end
                i_next = i_reg + 1'b1;
                if (last_i)
                begin
                    tot_next = '0;
                    cnt_next = '0;
                    if (found_reg || hit)
                        state_next = S_DSUM;
                    else
                    begin
                        k_next = cmd_reg.want;
                        state_next = S_DNEXT;
                    end
                end
            end
            S_DSUM:
            begin
                if (cur_v && cur_side == ds_reg && cur_p == bp_reg)
                begin
                    tot_next = tot_reg + 25'(cur_q);
                    cnt_next = cnt_reg + 6'd1;
                end
                i_next = i_reg + 1'b1;
                if (last_i)
                    state_next = S_DEMIT;
            end
            S_DEMIT:
            begin
                if (!oq_full)
                begin
                    o_push = 1'b1;
                    o_item.result_kind = ds_reg ? lobm_pkg::RK_ASK : lobm_pkg::RK_BID;
                    o_item.status = lobm_pkg::ST_BOOK;
                    o_item.level_price = bp_reg;
                    o_item.amount = tot_reg;
                    o_item.order_count = cnt_reg;
                    k_next = k_reg + 7'd1;
                    bnd_next = 1'b1;
                    bound_next = bp_reg;
                    state_next = S_DNEXT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        code_reg <= code_next;
        best_reg <= best_next;
        si_reg <= si_next;
        arr_reg <= arr_next;
        found_reg <= found_next;
        bp_reg <= bp_next;
        barr_reg <= barr_next;
        bq_reg <= bq_next;
        bid_reg <= bid_next;
        left_reg <= left_next;
        ds_reg <= ds_next;
        bnd_reg <= bnd_next;
        bound_reg <= bound_next;
        k_reg <= k_next;
        tot_reg <= tot_next;
        cnt_reg <= cnt_next;
        i_reg <= i_next;
        if (w_trade)
        begin
            sqty_reg[best_reg] <= bq_reg - ex;
        end
        if (w_new)
        begin
            sid_reg[free_idx] <= cmd_reg.id;
            sside_reg[free_idx] <= cmd_reg.side;
            sprice_reg[free_idx] <= cmd_reg.price;
            sqty_reg[free_idx] <= left_reg;
            sarr_reg[free_idx] <= {1'b0, arr_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            seen_cnt_reg <= '0;
            act_reg <= '0;
            for (int n = 0; n < lobm_pkg::NSLOT; n++)
            begin
                sv_reg[n] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            seen_cnt_reg <= seen_cnt_next;
            act_reg <= act_next;
            if (w_trade && ex == bq_reg)
                sv_reg[best_reg] <= 1'b0;
            if (w_clr)
                sv_reg[i_reg] <= 1'b0;
            if (w_new)
                sv_reg[free_idx] <= 1'b1;
        end
    end

endmodule

// File: design/limit_order_book_matcher_core.sv
// Channel   Direction  Ports                          Transfer
// request   in         push, full, req                push && !full
// result    out        pop, empty, res                pop && !empty
// config    in         cfg_valid, cfg_ready,          cfg_valid && cfg_ready
//                      cfg_index, cfg_data
//
// A request is registered into a two-entry command queue.
// The duplicate check reads the ID store one stored ID at a time. Every fill
// costs a sweep over the slot registers, a cancel a scan that stops at the
// matching slot or the last slot, and every depth level two sweeps.
// Results leave through a four-entry queue; when it is full the engine stalls.
// Reset is asynchronous and leaves the book and the ID store empty.
module limit_order_book_matcher_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  lobm_pkg::req_t  req,
    input  logic            pop,
    output logic            empty,
    output lobm_pkg::res_t  res,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [10:0]     cfg_data
);

    logic q_valid, q_pop, o_push, oq_full;
    lobm_pkg::cmd_t q_cmd;
    lobm_pkg::res_t o_item;
    lobm_pkg::res_t oq_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] ocnt_reg;
    logic [5:0] act_lim_reg;
    logic [10:0] seen_lim_reg;
    logic do_pop;

    lobm_front u_front (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .req(req),
        .q_valid(q_valid),
        .q_pop(q_pop),
        .q_cmd(q_cmd)
    );

    lobm_engine u_engine (
        .clk(clk),
        .rst_n(rst_n),
        .q_valid(q_valid),
        .q_pop(q_pop),
        .q_cmd(q_cmd),
        .oq_full(oq_full),
        .o_push(o_push),
        .o_item(o_item),
        .act_lim(act_lim_reg),
        .seen_lim(seen_lim_reg)
    );

    assign cfg_ready = 1'b1;
    assign oq_full = (ocnt_reg == 3'd4);
    assign empty = (ocnt_reg == 3'd0);
    assign res = oq_reg[rp_reg];
    assign do_pop = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (o_push)
        begin
            oq_reg[wp_reg] <= o_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            ocnt_reg <= '0;
            act_lim_reg <= 6'd32;
            seen_lim_reg <= 11'd1024;
        end
        else
        begin
            if (o_push)
                wp_reg <= wp_reg + 2'd1;
            if (do_pop)
                rp_reg <= rp_reg + 2'd1;
            ocnt_reg <= ocnt_reg + {2'b0, o_push} - {2'b0, do_pop};
            if (cfg_valid && cfg_index[1] == 1'b0)
            begin
                if (cfg_index[0] == lobm_pkg::CFG_ACTIVE_LIMIT)
                    act_lim_reg <= cfg_data[5:0];
                else if (cfg_index[0] == lobm_pkg::CFG_SEEN_LIMIT)
                    seen_lim_reg <= cfg_data;
            end
        end
    end

endmodule

// File: design/lobm_checker.sv
module lobm_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            pop,
    input logic            empty,
    input lobm_pkg::res_t  res
);

    a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> empty)
        else $error("result queue not empty after reset");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && res.last) |-> (res.result_kind == lobm_pkg::RK_ADD ||
            res.result_kind == lobm_pkg::RK_REJECT ||
            res.result_kind == lobm_pkg::RK_CANCEL ||
            res.result_kind == lobm_pkg::RK_END))
        else $error("final item of a request has a wrong kind");

    a_trade: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && res.result_kind == lobm_pkg::RK_TRADE) |->
            (res.maker_id != 32'd0 && res.amount != 25'd0 && !res.last))
        else $error("malformed trade item");

    a_level: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (res.result_kind == lobm_pkg::RK_BID ||
                    res.result_kind == lobm_pkg::RK_ASK)) |->
            (res.order_count != 6'd0 && res.status == lobm_pkg::ST_BOOK))
        else $error("malformed depth level item");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(res)))
        else $error("waiting result item changed");

endmodule

bind limit_order_book_matcher_core lobm_checker u_lobm_checker (
    .clk(clk),
    .rst_n(rst_n),
    .pop(pop),
    .empty(empty),
    .res(res)
);

// File: tb/limit_order_book_matcher_core_test.sv
module limit_order_book_matcher_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    class book_scoreboard;
        bit        slot_live [lobm_pkg::NSLOT];
        bit [31:0] slot_id [lobm_pkg::NSLOT];
        bit        slot_sell [lobm_pkg::NSLOT];
        bit [29:0] slot_px [lobm_pkg::NSLOT];
        bit [19:0] slot_qty [lobm_pkg::NSLOT];
        bit [10:0] slot_arr [lobm_pkg::NSLOT];
        bit [31:0] seen_ids [$];
        bit [5:0]  active_lim = 6'd32;
        bit [10:0] seen_lim = 11'd1024;
        lobm_pkg::res_t expected_q [$];
        int        errors = 0;
        int        items_in = 0;
        int        results_out = 0;

        function void set_reg(logic [1:0] idx, logic [10:0] data);
            if (idx == {1'b0, lobm_pkg::CFG_ACTIVE_LIMIT})
                active_lim = data[5:0];
            else if (idx == {1'b0, lobm_pkg::CFG_SEEN_LIMIT})
                seen_lim = data;
        endfunction

        function void put(logic [2:0] kind, logic [3:0] st, logic [31:0] taker,
                          logic [31:0] maker, logic [29:0] px, logic [24:0] amt,
                          logic [5:0] cnt, logic lst);
            lobm_pkg::res_t r;
            r.result_kind = kind;
            r.status = st;
            r.taker_id = taker;
            r.maker_id = maker;
            r.level_price = px;
            r.amount = amt;
            r.order_count = cnt;
            r.last = lst;
            expected_q.insert(expected_q.size(), r);
        endfunction

        function int best_slot(bit s);
            int b;
            bit better;
            b = -1;
            for (int i = 0; i < lobm_pkg::NSLOT; i++)
            begin
                if (!slot_live[i] || slot_sell[i] != s)
                    continue;
                if (b < 0)
                begin
                    b = i;
                    continue;
                end
                better = s ? (slot_px[i] < slot_px[b]) : (slot_px[i] > slot_px[b]);
                if (better || (slot_px[i] == slot_px[b] && slot_arr[i] < slot_arr[b]))
                    b = i;
            end
            return b;
        endfunction

        function void add_order(lobm_pkg::req_t r);
            logic [3:0] code;
            int live;
            int sl;
            int al;
            int b;
            bit [19:0] left;
            bit [19:0] ex;
            bit [10:0] arr;
            code = lobm_pkg::ST_OK;
            if (r.order_id == 0)
                code = lobm_pkg::ST_BAD_ID;
            else if (r.side > 1)
                code = lobm_pkg::ST_BAD_SIDE;
            else if (r.quantity == 0 || r.quantity > lobm_pkg::QTY_MAX)
                code = lobm_pkg::ST_BAD_QTY;
            else if (!r.is_market && (r.price == 0 || r.price > lobm_pkg::PRICE_MAX))
                code = lobm_pkg::ST_BAD_PRICE;
            else
                foreach (seen_ids[i])
                    if (seen_ids[i] == r.order_id)
                        code = lobm_pkg::ST_DUP;
            if (code == lobm_pkg::ST_OK)
            begin
                live = 0;
                foreach (slot_live[i])
                    live += int'(slot_live[i]);
                sl = (seen_lim < lobm_pkg::NSEEN) ? int'(seen_lim) : lobm_pkg::NSEEN;
                al = (active_lim < lobm_pkg::NSLOT) ? int'(active_lim) : lobm_pkg::NSLOT;
                if (seen_ids.size() >= sl || live >= al)
                    code = lobm_pkg::ST_CAPACITY;
            end
            if (code != lobm_pkg::ST_OK)
            begin
                put(lobm_pkg::RK_REJECT, code, r.order_id, 0, 0, 0, 0, 1);
                return;
            end
            arr = 11'(seen_ids.size());
            seen_ids.insert(seen_ids.size(), r.order_id);
            left = r.quantity;
            while (left > 0)
            begin
                b = best_slot(!r.side[0]);
                if (b < 0)
                    break;
                if (!r.is_market && (r.side[0] == 0 ? (slot_px[b] > r.price)
                                                    : (slot_px[b] < r.price)))
                    break;
                ex = (left < slot_qty[b]) ? left : slot_qty[b];
                put(lobm_pkg::RK_TRADE, lobm_pkg::ST_OK, r.order_id, slot_id[b], slot_px[b],
                    25'(ex), 0, 0);
                left -= ex;
                slot_qty[b] -= ex;
                if (slot_qty[b] == 0)
                    slot_live[b] = 0;
            end
            if (left > 0 && !r.is_market)
            begin
                for (int i = 0; i < lobm_pkg::NSLOT; i++)
                begin
                    if (!slot_live[i])
                    begin
                        slot_live[i] = 1;
                        slot_id[i] = r.order_id;
                        slot_sell[i] = r.side[0];
                        slot_px[i] = r.price;
                        slot_qty[i] = left;
                        slot_arr[i] = arr;
                        break;
                    end
                end
            end
            put(lobm_pkg::RK_ADD,
                (r.is_market && left > 0) ? lobm_pkg::ST_EXPIRED : lobm_pkg::ST_OK,
                r.order_id, 0, 0, 25'(left), 0, 1);
        endfunction

        function void cancel_order(lobm_pkg::req_t r);
            for (int i = 0; i < lobm_pkg::NSLOT; i++)
            begin
                if (slot_live[i] && slot_id[i] == r.order_id && r.order_id != 0)
                begin
                    slot_live[i] = 0;
                    put(lobm_pkg::RK_CANCEL, lobm_pkg::ST_CANCELLED, r.order_id, 0, 0,
                        25'(slot_qty[i]), 0, 1);
                    return;
                end
            end
            put(lobm_pkg::RK_REJECT, lobm_pkg::ST_UNKNOWN, r.order_id, 0, 0, 0, 0, 1);
        endfunction

        function void depth_report(lobm_pkg::req_t r);
            int want;
            bit bounded;
            bit found;
            bit [29:0] bound;
            bit [29:0] bp;
            bit [24:0] total;
            bit [5:0] cnt;
            want = (r.depth_levels > lobm_pkg::DEPTH_CAP) ? int'(lobm_pkg::DEPTH_CAP)
                                                          : int'(r.depth_levels);
            for (int s = 0; s < 2; s++)
            begin
                bounded = 0;
                bound = 0;
                for (int k = 0; k < want; k++)
                begin
                    found = 0;
                    bp = 0;
                    for (int i = 0; i < lobm_pkg::NSLOT; i++)
                    begin
                        if (!slot_live[i] || slot_sell[i] != s)
                            continue;
                        if (bounded && (s == 0 ? slot_px[i] >= bound : slot_px[i] <= bound))
                            continue;
                        if (!found || (s == 0 ? slot_px[i] > bp : slot_px[i] < bp))
                        begin
                            bp = slot_px[i];
                            found = 1;
                        end
                    end
                    if (!found)
                        break;
                    total = 0;
                    cnt = 0;
                    for (int i = 0; i < lobm_pkg::NSLOT; i++)
                    begin
                        if (slot_live[i] && slot_sell[i] == s && slot_px[i] == bp)
                        begin
                            total += 25'(slot_qty[i]);
                            cnt++;
                        end
                    end
                    put(s ? lobm_pkg::RK_ASK : lobm_pkg::RK_BID, lobm_pkg::ST_BOOK, 0, 0,
                        bp, total, cnt, 0);
                    bounded = 1;
                    bound = bp;
                end
            end
            put(lobm_pkg::RK_END, lobm_pkg::ST_BOOK, 0, 0, 0, 0, 0, 1);
        endfunction

        function void note_request(lobm_pkg::req_t r);
            items_in++;
            case (r.req_type)
                lobm_pkg::REQ_ADD: add_order(r);
                lobm_pkg::REQ_CANCEL: cancel_order(r);
                lobm_pkg::REQ_DEPTH: depth_report(r);
                default: ;
            endcase
        endfunction

        function void cmp(string field, logic [31:0] e, logic [31:0] a);
            if (e !== a)
            begin
                $error("%s mismatch: expected %0d, got %0d", field, e, a);
                errors++;
            end
        endfunction

        function void check_result(lobm_pkg::res_t got);
            lobm_pkg::res_t e;
            results_out++;
            if (expected_q.size() == 0)
            begin
                $error("result with nothing expected: %p", got);
                errors++;
                return;
            end
            e = expected_q[0];
            expected_q.delete(0);
            cmp("result_kind", 32'(e.result_kind), 32'(got.result_kind));
            cmp("status", 32'(e.status), 32'(got.status));
            cmp("taker_id", e.taker_id, got.taker_id);
            cmp("maker_id", e.maker_id, got.maker_id);
            cmp("level_price", 32'(e.level_price), 32'(got.level_price));
            cmp("amount", 32'(e.amount), 32'(got.amount));
            cmp("order_count", 32'(e.order_count), 32'(got.order_count));
            cmp("last", 32'(e.last), 32'(got.last));
        endfunction

        function bit [31:0] pick_seen_id();
            if (seen_ids.size() == 0)
                return 32'd7;
            return seen_ids[$urandom_range(seen_ids.size() - 1)];
        endfunction

        function bit [31:0] pick_resting_id();
            int live_idx [$];
            foreach (slot_live[i])
                if (slot_live[i])
                    live_idx.insert(live_idx.size(), i);
            if (live_idx.size() == 0)
                return pick_seen_id();
            return slot_id[live_idx[$urandom_range(live_idx.size() - 1)]];
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           push;
    logic           full;
    lobm_pkg::req_t req;
    logic           pop;
    logic           empty;
    lobm_pkg::res_t res;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [1:0]     cfg_index;
    logic [10:0]    cfg_data;

    book_scoreboard book;
    int tx_pct = 0;
    int rx_pct = 0;
    int rx_hold = 0;
    bit [31:0] next_id = 32'd1000;

    limit_order_book_matcher_core u_top (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .req(req),
        .pop(pop),
        .empty(empty),
        .res(res),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #80_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                book.check_result(res);
            if (rx_hold > 0)
            begin
                rx_hold--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= rx_pct);
        end
    end

    task automatic send(lobm_pkg::req_t r);
        while (tx_pct > 0 && $urandom_range(99) < tx_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (full);
        book.note_request(r);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [10:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        book.set_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (book.expected_q.size() != 0)
            @(posedge clk);
        repeat (4000) @(posedge clk);
    endtask

    function automatic lobm_pkg::req_t mk(logic [1:0] kind, logic [31:0] id,
                                          logic [1:0] side, logic mkt, logic [29:0] px,
                                          logic [19:0] qty, logic [7:0] lv);
        lobm_pkg::req_t r;
        r.req_type = kind;
        r.order_id = id;
        r.side = side;
        r.is_market = mkt;
        r.price = px;
        r.quantity = qty;
        r.depth_levels = lv;
        return r;
    endfunction

    function automatic lobm_pkg::req_t random_item();
        lobm_pkg::req_t r;
        int pick;
        int sub;
        r = lobm_pkg::req_t'(95'({$urandom, $urandom, $urandom}));
        pick = $urandom_range(99);
        sub = $urandom_range(99);
        if (pick < 65)
        begin
            r.req_type = lobm_pkg::REQ_ADD;
            if (sub < 85)
            begin
                r.order_id = next_id;
                next_id++;
            end
            else if (sub < 90)
                r.order_id = 0;
            else if (sub < 95)
                r.order_id = book.pick_seen_id();
            if ($urandom_range(99) < 95)
                r.side = 2'($urandom_range(1));
            else
                r.side = 2'(2 + $urandom_range(1));
            r.is_market = ($urandom_range(99) < 15);
            if ($urandom_range(99) < 90)
                r.price = 30'(990 + $urandom_range(20));
            sub = $urandom_range(99);
            if (sub < 85)
                r.quantity = 20'(1 + $urandom_range(59));
            else if (sub < 90)
                r.quantity = 0;
            else if (sub < 95)
                r.quantity = 20'($urandom_range(1000000));
        end
        else if (pick < 85)
        begin
            r.req_type = lobm_pkg::REQ_CANCEL;
            if (sub < 70)
                r.order_id = book.pick_resting_id();
            else if (sub < 80)
                r.order_id = 0;
        end
        else if (pick < 97)
        begin
            r.req_type = lobm_pkg::REQ_DEPTH;
            if (sub < 50)
                r.depth_levels = 8'(1 + $urandom_range(4));
        end
        else
            r.req_type = lobm_pkg::REQ_UNUSED;
        return r;
    endfunction

    task automatic run_phase(int n, int txp, int rxp);
        tx_pct = txp;
        rx_pct = rxp;
        repeat (n) send(random_item());
        drain();
    endtask

    initial
    begin
        book = new();
        rst_n = 1'b0;
        push = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(mk(lobm_pkg::REQ_DEPTH, 0, 0, 0, 0, 0, 8'd5));
        send(mk(lobm_pkg::REQ_ADD, 0, 0, 0, 1000, 10, 0));
        send(mk(lobm_pkg::REQ_ADD, 50, 2, 0, 1000, 10, 0));
        send(mk(lobm_pkg::REQ_ADD, 51, 3, 0, 1000, 10, 0));
        send(mk(lobm_pkg::REQ_ADD, 52, 0, 0, 1000, 0, 0));
        send(mk(lobm_pkg::REQ_ADD, 53, 1, 0, 1000, 20'd1000001, 0));
        send(mk(lobm_pkg::REQ_ADD, 54, 0, 0, 0, 10, 0));
        send(mk(lobm_pkg::REQ_ADD, 55, 1, 0, 30'd1000000001, 10, 0));
        send(mk(lobm_pkg::REQ_ADD, 56, 0, 0, 30'h3FFFFFFF, 20'hFFFFF, 8'hFF));
        send(mk(lobm_pkg::REQ_ADD, 100, 0, 0, 1000, 10, 0));
        send(mk(lobm_pkg::REQ_ADD, 100, 0, 0, 1000, 10, 0));
        send(mk(lobm_pkg::REQ_ADD, 101, 1, 0, lobm_pkg::PRICE_MAX, lobm_pkg::QTY_MAX, 0));
        send(mk(lobm_pkg::REQ_ADD, 102, 0, 0, 1, 1, 0));
        send(mk(lobm_pkg::REQ_ADD, 103, 1, 1, 0, 5, 0));
        send(mk(lobm_pkg::REQ_ADD, 104, 1, 1, 30'h3FFFFFFF, 100, 0));
        send(mk(lobm_pkg::REQ_ADD, 105, 0, 1, 0, 3, 0));
        send(mk(lobm_pkg::REQ_ADD, 106, 0, 0, 999, 4, 0));
        send(mk(lobm_pkg::REQ_DEPTH, 0, 0, 0, 0, 0, 8'd255));
        send(mk(lobm_pkg::REQ_CANCEL, 101, 0, 0, 0, 0, 0));
        send(mk(lobm_pkg::REQ_CANCEL, 101, 0, 0, 0, 0, 0));
        send(mk(lobm_pkg::REQ_CANCEL, 0, 0, 0, 0, 0, 0));
        send(mk(lobm_pkg::REQ_DEPTH, 0, 0, 0, 0, 0, 8'd0));
        send(mk(lobm_pkg::REQ_UNUSED, 32'hFFFFFFFF, 3, 1, 30'h3FFFFFFF, 20'hFFFFF, 8'hFF));
        drain();

        run_phase(80, 0, 0);

        rx_hold = 3000;
        run_phase(80, 64, 0);

        write_reg({1'b0, lobm_pkg::CFG_ACTIVE_LIMIT}, 11'd1);
        write_reg({1'b0, lobm_pkg::CFG_SEEN_LIMIT}, 11'd2047);
        run_phase(60, 0, 64);

        write_reg({1'b0, lobm_pkg::CFG_ACTIVE_LIMIT}, 11'd63);
        write_reg({1'b0, lobm_pkg::CFG_SEEN_LIMIT}, 11'd0);
        run_phase(30, 19, 19);

        write_reg({1'b0, lobm_pkg::CFG_ACTIVE_LIMIT}, 11'd0);
        write_reg({1'b0, lobm_pkg::CFG_SEEN_LIMIT}, 11'd1024);
        run_phase(20, 0, 0);

        write_reg({1'b0, lobm_pkg::CFG_ACTIVE_LIMIT}, 11'd8);
        write_reg({1'b0, lobm_pkg::CFG_SEEN_LIMIT}, 11'(book.seen_ids.size() + 40));
        run_phase(100, 19, 19);

        write_reg({1'b0, lobm_pkg::CFG_ACTIVE_LIMIT}, 11'd32);
        write_reg({1'b0, lobm_pkg::CFG_SEEN_LIMIT}, 11'd2047);
        run_phase(80, 0, 0);

        $display("Covered %0d requests and %0d results over six register settings.",
                 book.items_in, book.results_out);
        $display("Book held %0d accepted order IDs at the end.", book.seen_ids.size());
        if (book.errors == 0 && book.expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
